>>> hw/rtl/hrcv_pkg.sv
// Shared types and constants for the header recurrence checksum validator.
// Used by hrcv_front, hrcv_queue, hrcv_back and the top level; no dependencies.
package hrcv_pkg;

  // Header layout and sizes.
  localparam int PAYLOAD_MAX   = 8;
  localparam int COUNT_W       = $clog2(PAYLOAD_MAX + 1);
  localparam int IDX_W         = $clog2(PAYLOAD_MAX);

  localparam logic [4:0] POS_ADDR      = 5'd4;
  localparam logic [4:0] POS_LEN       = 5'd12;
  localparam logic [4:0] POS_PAYLOAD   = 5'd14;
  localparam logic [4:0] POS_CHECKSUM  = 5'd22;
  localparam logic [4:0] CHECKED_BYTES = 5'd22;
  localparam logic [4:0] HEADER_BYTES  = 5'd26;
  localparam logic [4:0] LAST_HDR_POS  = 5'd25;

  // File magic, first byte in the lowest lane.
  localparam logic [3:0][7:0] MAGIC = {8'h48, 8'h4B, 8'h4E, 8'h41};

  // Recurrence constants.
  localparam logic [15:0] TERM_SEED = 16'd7;
  localparam logic [7:0]  COEF_A    = 8'd17;
  localparam logic [7:0]  COEF_B    = 8'd31;
  localparam logic [16:0] TERM_MOD  = 17'd65535;
  // A multiple of the modulus larger than any subtracted product.
  localparam logic [25:0] TERM_BIAS = 26'd16776960;

  localparam logic [15:0] LOAD_ADDR_RESET = 16'h0100;

  // Status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_SHORT     = 3'd1;
  localparam status_t ST_BAD_MAGIC = 3'd2;
  localparam status_t ST_BAD_ADDR  = 3'd3;
  localparam status_t ST_BAD_SUM   = 3'd4;

  // One command from the front to the back: a status and, on success,
  // the payload bytes to release. A count of zero means a single status word.
  typedef struct packed {
    status_t                          status;
    logic [COUNT_W-1:0]               count;
    logic [PAYLOAD_MAX-1:0][7:0]      bytes;
  } cmd_t;

endpackage

>>> hw/rtl/header_recurrence_checksum_validator.sv
// Top level of the header recurrence checksum validator.
// Depends on hrcv_pkg, hrcv_front, hrcv_queue and hrcv_back.
//
// Usage: file bytes enter on the s_ stream, one word per byte, with s_tlast
// on the file's last byte. After the 26th header byte the block checks the
// magic, the load address against the cfg_ register (reset 0x0100) and the
// recurrence checksum over the first 22 bytes, then emits one status word,
// or on success one word per payload byte when the length is 1 to 8.
// s_tlast before the header is complete gives a short-file status. Bytes
// after the header are dropped up to s_tlast.
// Throughput: one input byte per cycle while the command queue has room, as the
// recurrence update in the front part is combinational; results leave at one word
// per cycle while the receiver is ready. The results of a header are written into
// the command queue as its last byte is accepted and from there loaded into the
// output register.
// When the receiver stalls, results wait in the output register and the
// two-entry command queue; input is refused only once that queue is full.
// Reset clears the file position and restores the register's reset value;
// configuration is written with cfg_valid, always ready.
module header_recurrence_checksum_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] status, [10:3] payload_byte, [15:11] zero
  output logic        m_tlast,   // last_result
  output logic        m_tuser,   // [0] payload_present
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // expected_load_address
);

  logic           push;
  hrcv_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           head_valid;
  hrcv_pkg::cmd_t head;
  logic           pop;

  assign cfg_ready = 1'b1;

  hrcv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  hrcv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  hrcv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

>>> hw/rtl/hrcv_front.sv
// Front part: accepts file bytes, parses the header and runs the checksum.
// Depends on hrcv_pkg; pushes one command per finished header or short file.
module hrcv_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             cfg_valid,
  input  logic [15:0]      cfg_data,
  input  logic             q_full,
  output logic             push,
  output hrcv_pkg::cmd_t   push_cmd
);

  logic [4:0]  byte_count;
  logic        skipping;
  logic        magic_good;
  logic [15:0] expected_load_address;
  logic [15:0] header_addr;
  logic [15:0] payload_length;
  logic [23:0] stored_checksum;
  logic [15:0] older_term;
  logic [15:0] newer_term;
  logic [hrcv_pkg::PAYLOAD_MAX-1:0][7:0] payload_store;

  logic        accept;
  logic        at_end;
  logic [4:0]  store_off;
  logic [7:0]  mul_a;
  logic [7:0]  mul_b;
  logic [8:0]  add_a;
  logic [24:0] prod_a;
  logic [23:0] prod_b;
  logic [25:0] diff;
  logic [25:0] biased;
  logic [16:0] fold;
  logic [15:0] term_next;
  logic        len_ok;
  hrcv_pkg::status_t final_status;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign at_end   = (byte_count == hrcv_pkg::LAST_HDR_POS);
  assign store_off = byte_count - hrcv_pkg::POS_PAYLOAD;

  // Recurrence term: both products in parallel, then a fold modulo 65535.
  always_comb begin
    mul_a  = 8'({3'b0, byte_count} * hrcv_pkg::COEF_A);
    mul_b  = 8'({3'b0, byte_count} * hrcv_pkg::COEF_B);
    add_a  = {1'b0, s_tdata} + {1'b0, mul_a};
    prod_a = {16'b0, add_a} * {9'b0, newer_term};
    prod_b = {16'b0, mul_b} * {8'b0, older_term};
    diff   = {1'b0, prod_a} - {2'b0, prod_b};
    // A negative difference wraps one step further, as a 64-bit wrap would.
    biased = diff + hrcv_pkg::TERM_BIAS + {25'b0, diff[25]};
    fold   = {1'b0, biased[15:0]} + {7'b0, biased[25:16]};
    if (fold >= hrcv_pkg::TERM_MOD) begin
      term_next = 16'(fold - hrcv_pkg::TERM_MOD);
    end else begin
      term_next = fold[15:0];
    end
  end

  // Checks made when the last header byte arrives.
  always_comb begin
    len_ok = (payload_length != 16'd0) &&
             (payload_length <= 16'(hrcv_pkg::PAYLOAD_MAX));
    if (!magic_good) begin
      final_status = hrcv_pkg::ST_BAD_MAGIC;
    end else if (header_addr != expected_load_address) begin
      final_status = hrcv_pkg::ST_BAD_ADDR;
    end else if ({s_tdata, stored_checksum} != {16'b0, newer_term}) begin
      final_status = hrcv_pkg::ST_BAD_SUM;
    end else begin
      final_status = hrcv_pkg::ST_OK;
    end
  end

  // Command towards the back part.
  always_comb begin
    push = accept && !skipping && (at_end || s_tlast);
    push_cmd.bytes = payload_store;
    if (at_end) begin
      push_cmd.status = final_status;
      if ((final_status == hrcv_pkg::ST_OK) && len_ok) begin
        push_cmd.count = payload_length[hrcv_pkg::COUNT_W-1:0];
      end else begin
        push_cmd.count = '0;
      end
    end else begin
      push_cmd.status = hrcv_pkg::ST_SHORT;
      push_cmd.count  = '0;
    end
  end

  // Control state: position in the file, magic flag, tail skipping and load address.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count            <= '0;
      skipping              <= 1'b0;
      magic_good            <= 1'b1;
      expected_load_address <= hrcv_pkg::LOAD_ADDR_RESET;
    end else begin
      if (cfg_valid) begin
        expected_load_address <= cfg_data;
      end
      if (accept) begin
        if (skipping) begin
          if (s_tlast) begin
            skipping   <= 1'b0;
            byte_count <= '0;
            magic_good <= 1'b1;
          end
        end else if (s_tlast) begin
          byte_count <= '0;
          magic_good <= 1'b1;
        end else begin
          if ((byte_count < hrcv_pkg::POS_ADDR) &&
              (s_tdata != hrcv_pkg::MAGIC[byte_count[1:0]])) begin
            magic_good <= 1'b0;
          end
          if (at_end) begin
            byte_count <= hrcv_pkg::HEADER_BYTES;
            skipping   <= 1'b1;
          end else begin
            byte_count <= byte_count + 5'd1;
          end
        end
      end
    end
  end

  // Header fields and checksum terms; every field is written before use.
  always_ff @(posedge clk) begin
    if (accept && !skipping) begin
      if (byte_count == hrcv_pkg::POS_ADDR) begin
        header_addr[7:0] <= s_tdata;
      end else if (byte_count == hrcv_pkg::POS_ADDR + 5'd1) begin
        header_addr[15:8] <= s_tdata;
      end else if (byte_count == hrcv_pkg::POS_LEN) begin
        payload_length[7:0] <= s_tdata;
      end else if (byte_count == hrcv_pkg::POS_LEN + 5'd1) begin
        payload_length[15:8] <= s_tdata;
      end else if ((byte_count >= hrcv_pkg::POS_PAYLOAD) &&
                   (byte_count < hrcv_pkg::POS_CHECKSUM)) begin
        payload_store[store_off[hrcv_pkg::IDX_W-1:0]] <= s_tdata;
      end else if (byte_count == hrcv_pkg::POS_CHECKSUM) begin
        stored_checksum[7:0] <= s_tdata;
      end else if (byte_count == hrcv_pkg::POS_CHECKSUM + 5'd1) begin
        stored_checksum[15:8] <= s_tdata;
      end else if (byte_count == hrcv_pkg::POS_CHECKSUM + 5'd2) begin
        stored_checksum[23:16] <= s_tdata;
      end
      if (byte_count == 5'd0) begin
        older_term <= 16'd1;
        newer_term <= {8'b0, s_tdata} + hrcv_pkg::TERM_SEED;
      end else if (byte_count < hrcv_pkg::CHECKED_BYTES) begin
        older_term <= newer_term;
        newer_term <= term_next;
      end
    end
  end

  // While skipping the tail the count rests just past the header.
  assert property (@(posedge clk) disable iff (rst)
    skipping |-> (byte_count == hrcv_pkg::HEADER_BYTES))
    else $error("tail skipping with a header position still open");
  assert property (@(posedge clk) disable iff (rst)
    !skipping |-> (byte_count < hrcv_pkg::HEADER_BYTES))
    else $error("header position past the last header byte");

endmodule

>>> hw/rtl/hrcv_queue.sv
// Two-entry command queue between the front and the back part.
// Depends on hrcv_pkg for the command type.
module hrcv_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hrcv_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output hrcv_pkg::cmd_t   head
);

  localparam int DEPTH = 2;

  hrcv_pkg::cmd_t entries [DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'(DEPTH));
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("command popped from an empty queue");

endmodule

>>> hw/rtl/hrcv_back.sv
// Back part: turns commands into result words, one word per cycle while the receiver is ready.
// Depends on hrcv_pkg; drives the registered output stream.
module hrcv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  hrcv_pkg::cmd_t   head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  logic                          active;
  hrcv_pkg::cmd_t                cur;
  logic [hrcv_pkg::IDX_W-1:0]    idx;

  logic                          load_ok;
  logic                          src_valid;
  hrcv_pkg::cmd_t                src;
  logic [hrcv_pkg::IDX_W-1:0]    src_idx;
  logic                          has_payload;
  logic                          is_last;
  logic                          emit;

  // Pick the next word: the command in progress, else the queue head.
  always_comb begin
    load_ok     = !m_tvalid || m_tready;
    src_valid   = active || head_valid;
    src         = active ? cur : head;
    src_idx     = active ? idx : '0;
    has_payload = (src.count != '0);
    is_last     = !has_payload ||
                  ({1'b0, src_idx} == src.count - hrcv_pkg::COUNT_W'(1));
    emit        = load_ok && src_valid;
    pop         = emit && !active;
  end

  // Output register and payload walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      active   <= 1'b0;
    end else begin
      if (load_ok) begin
        m_tvalid <= src_valid;
      end
      if (emit) begin
        m_tdata <= {5'b0, (has_payload ? src.bytes[src_idx] : 8'h00), src.status};
        m_tuser <= has_payload;
        m_tlast <= is_last;
        if (is_last) begin
          active <= 1'b0;
        end else begin
          active <= 1'b1;
          cur    <= src;
          idx    <= src_idx + hrcv_pkg::IDX_W'(1);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[2:0] == hrcv_pkg::ST_OK))
    else $error("payload word carries a failing status");
  assert property (@(posedge clk) disable iff (rst)
    active |-> ({1'b0, idx} < cur.count))
    else $error("payload walk ran past the payload length");

endmodule
